// ----- hw/rtl/sac_pkg.sv -----
// ----------------------------------------------------------------------------
// sac_pkg: shared types and constants of the standard atmosphere calculator
// Layer codes, the context word that travels with each sample, per-layer
// constants and a reciprocal divide helper for small constant divisors.
// ----------------------------------------------------------------------------
package sac_pkg;

  localparam int QBITS = 30;
  localparam logic [30:0] QONE = 31'h4000_0000;
  localparam logic [29:0] LN2_Q = 30'd744261118;
  localparam logic [15:0] ALT_MAX = 16'd51000;
  localparam logic [16:0] D_SAT = 17'd131071;

  typedef enum logic [2:0] {
    LYR_TROPO,
    LYR_TROPOPAUSE,
    LYR_STRATO_LOW,
    LYR_STRATO_HIGH,
    LYR_STRATOPAUSE
  } lyr_t;

  typedef struct packed {
    logic [16:0] tq8;
    logic [21:0] t;
    lyr_t        lyr;
    logic [13:0] dh;
    logic        oor;
  } ctx_t;

  // Pressure at the layer base, pascal * 10.
  function automatic logic [19:0] layer_base(input lyr_t lyr);
    logic [19:0] b;
    case (lyr)
      LYR_TROPO:       b = 20'd1013250;
      LYR_TROPOPAUSE:  b = 20'd226321;
      LYR_STRATO_LOW:  b = 20'd54555;
      LYR_STRATO_HIGH: b = 20'd8585;
      LYR_STRATOPAUSE: b = 20'd1089;
      default:         b = 20'd0;
    endcase
    return b;
  endfunction

  // Exponent divisor: lapse * R for gradient layers, 10 * R * T for isothermal.
  function automatic logic [32:0] exp_den(input lyr_t lyr);
    logic [32:0] d;
    case (lyr)
      LYR_TROPO:       d = 33'd1865825;
      LYR_TROPOPAUSE:  d = 33'd6204872800;
      LYR_STRATO_LOW:  d = 33'd287050;
      LYR_STRATO_HIGH: d = 33'd803740;
      LYR_STRATOPAUSE: d = 33'd7754942800;
      default:         d = 33'd1;
    endcase
    return d;
  endfunction

  // Base temperature of the gradient layers, 1e-4 K.
  function automatic logic [21:0] layer_tb(input lyr_t lyr, input logic [21:0] t);
    logic [21:0] tb;
    case (lyr)
      LYR_TROPO:       tb = 22'd2881600;
      LYR_STRATO_LOW:  tb = 22'd2161600;
      LYR_STRATO_HIGH: tb = 22'd2281600;
      default:         tb = t;
    endcase
    return tb;
  endfunction

  // floor(m / n) from rcp = floor(2^32 / n): estimate low by at most one, fix up.
  function automatic logic [31:0] recip_div(input logic [31:0] m, input logic [31:0] rcp,
                                            input logic [9:0] n);
    logic [63:0] prod;
    logic [31:0] q0;
    logic [41:0] back;
    logic [31:0] rem;
    prod = 64'(m) * 64'(rcp);
    q0   = prod[63:32];
    back = 42'(q0) * 42'(n);
    rem  = m - back[31:0];
    if (rem >= 32'(n)) begin
      q0 = q0 + 32'd1;
    end
    return q0;
  endfunction

endpackage

// ----- hw/rtl/standard_atmosphere_calc.sv -----
// ----------------------------------------------------------------------------
// standard_atmosphere_calc: standard atmosphere, sea level to 51000 m
// Pipeline: 122 register stages from the input register to out_*.
// Throughput: one word per cycle unless stalled, set by the fully pipelined
//   dividers (one quotient bit per stage) and two-stage Horner steps of exp.
// Reset: rst_n low clears every valid bit; no clearing pass, ready at once.
// ----------------------------------------------------------------------------
module standard_atmosphere_calc (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] altitude_m
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [16:0] temperature_q8, [37:17] pressure_q4,
                                  // [54:38] density_q16, [55] zero
  output logic        out_tuser   // [0] out_of_range
);

  localparam int CTX_W = $bits(sac_pkg::ctx_t);
  localparam int SD3_W = 21 + CTX_W;
  localparam logic [31:0] RCP_625 = 32'((64'd1 << 32) / 625);
  localparam logic [31:0] RCP_5   = 32'((64'd1 << 32) / 5);

  // Whole pipeline advances together; hold everything while the output waits.
  logic en;
  logic out_vld_r;
  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  // ---------------- S0: capture the altitude word
  logic        v0_r;
  logic [15:0] h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_r <= in_tdata;
    end
  end

  // ---------------- S1: layer decode and temperature in 1e-4 K
  sac_pkg::lyr_t lyr_nxt;
  logic [21:0]   t_nxt;
  logic [13:0]   dh_nxt;
  logic          oor_nxt;

  always_comb begin
    oor_nxt = h_r > sac_pkg::ALT_MAX;
    dh_nxt  = 14'd0;
    // Pressure layers close at the top; 11000 m stays in the troposphere.
    if (h_r <= 16'd11000) begin
      lyr_nxt = sac_pkg::LYR_TROPO;
    end else if (h_r <= 16'd20000) begin
      lyr_nxt = sac_pkg::LYR_TROPOPAUSE;
    end else if (h_r <= 16'd32000) begin
      lyr_nxt = sac_pkg::LYR_STRATO_LOW;
    end else if (h_r <= 16'd47000) begin
      lyr_nxt = sac_pkg::LYR_STRATO_HIGH;
    end else begin
      lyr_nxt = sac_pkg::LYR_STRATOPAUSE;
    end
    case (lyr_nxt)
      sac_pkg::LYR_TROPO: begin
        // The seam at 11000 m already takes the isothermal temperature.
        if (h_r == 16'd11000) begin
          t_nxt = 22'd2161600;
        end else begin
          t_nxt = 22'd2881600 - 22'(h_r) * 22'd65;
        end
      end
      sac_pkg::LYR_TROPOPAUSE: begin
        t_nxt  = 22'd2161600;
        dh_nxt = 14'(h_r - 16'd11000);
      end
      sac_pkg::LYR_STRATO_LOW: begin
        t_nxt = 22'd2161600 + 22'(h_r - 16'd20000) * 22'd10;
      end
      sac_pkg::LYR_STRATO_HIGH: begin
        t_nxt = 22'd2281600 + 22'(h_r - 16'd32000) * 22'd28;
      end
      default: begin
        t_nxt  = 22'd2701600;
        dh_nxt = 14'(h_r - 16'd47000);
      end
    endcase
  end

  logic          v1_r;
  logic [21:0]   t1_r;
  sac_pkg::lyr_t lyr1_r;
  logic [13:0]   dh1_r;
  logic          oor1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r   <= t_nxt;
      lyr1_r <= lyr_nxt;
      dh1_r  <= dh_nxt;
      oor1_r <= oor_nxt;
    end
  end

  // ---------------- S2: Q8 temperature and the log-ratio divide operands
  logic [21:0]     tb;
  logic [21:0]     d_nxt;
  logic [22:0]     s_nxt;
  logic [50:0]     num_u_nxt;
  sac_pkg::ctx_t   ctx_nxt;

  always_comb begin
    tb    = sac_pkg::layer_tb(lyr1_r, t1_r);
    d_nxt = (t1_r > tb) ? (t1_r - tb) : (tb - t1_r);
    s_nxt = 23'(t1_r) + 23'(tb);
    // round(d * 2^30 / s): add half the divisor
    num_u_nxt = (51'(d_nxt) << sac_pkg::QBITS) + 51'(s_nxt >> 1);
    // (t * 256 + 5000) / 10000 == (t * 16 + 312) / 625
    ctx_nxt.tq8 = 17'(sac_pkg::recip_div(32'(t1_r) * 32'd16 + 32'd312, RCP_625, 10'd625));
    ctx_nxt.t   = t1_r;
    ctx_nxt.lyr = lyr1_r;
    ctx_nxt.dh  = dh1_r;
    ctx_nxt.oor = oor1_r;
  end

  logic          v2_r;
  logic [50:0]   num_u_r;
  logic [22:0]   den_u_r;
  sac_pkg::ctx_t ctx2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_u_r <= num_u_nxt;
      den_u_r <= s_nxt;
      ctx2_r  <= ctx_nxt;
    end
  end

  // ---------------- u = |t - tb| / (t + tb)
  logic             vu;
  logic [27:0]      u;
  logic [CTX_W-1:0] su;

  sac_div_pipe #(
    .NUM_W  (51),
    .DEN_W  (23),
    .QUO_W  (28),
    .SIDE_W (CTX_W)
  ) u_div_u (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v2_r),
    .in_num   (num_u_r),
    .in_den   (den_u_r),
    .in_side  (ctx2_r),
    .out_vld  (vu),
    .out_quo  (u),
    .out_side (su)
  );

  // ---------------- ln magnitude
  logic             vl;
  logic [28:0]      ln;
  logic [CTX_W-1:0] sl;

  sac_series #(
    .SIDE_W (CTX_W)
  ) u_series (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vu),
    .in_u     (u),
    .in_side  (su),
    .out_vld  (vl),
    .out_ln   (ln),
    .out_side (sl)
  );

  // ---------------- E1/E2: exponent numerator
  // Gradient layers: ln * g * 10; isothermal layers: (g * dh) << 30.
  sac_pkg::ctx_t ctx_l;
  logic          iso_l;
  logic [28:0]   ma;
  logic [23:0]   mb;

  assign ctx_l = sac_pkg::ctx_t'(sl);
  assign iso_l = (ctx_l.lyr == sac_pkg::LYR_TROPOPAUSE) ||
                 (ctx_l.lyr == sac_pkg::LYR_STRATOPAUSE);
  assign ma    = iso_l ? 29'(ctx_l.dh) : ln;
  assign mb    = iso_l ? 24'd980665 : 24'd9806650;

  logic          ve1_r;
  logic          iso1_r;
  logic [52:0]   mul1_r;
  sac_pkg::ctx_t ctxe1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve1_r <= 1'b0;
    end else if (en) begin
      ve1_r <= vl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      iso1_r  <= iso_l;
      mul1_r  <= 53'(ma) * 53'(mb);
      ctxe1_r <= ctx_l;
    end
  end

  logic [32:0] den_e_nxt;
  logic [63:0] num_e_nxt;

  assign den_e_nxt = sac_pkg::exp_den(ctxe1_r.lyr);
  assign num_e_nxt = (iso1_r ? (64'(mul1_r) << sac_pkg::QBITS) : 64'(mul1_r)) +
                     64'(den_e_nxt >> 1);

  logic          ve2_r;
  logic [63:0]   num_e_r;
  logic [32:0]   den_e_r;
  sac_pkg::ctx_t ctxe2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve2_r <= 1'b0;
    end else if (en) begin
      ve2_r <= ve1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_e_r <= num_e_nxt;
      den_e_r <= den_e_nxt;
      ctxe2_r <= ctxe1_r;
    end
  end

  // ---------------- y, exponent magnitude in Q30
  logic             vy;
  logic [31:0]      y;
  logic [CTX_W-1:0] sy;

  sac_div_pipe #(
    .NUM_W  (64),
    .DEN_W  (33),
    .QUO_W  (32),
    .SIDE_W (CTX_W)
  ) u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (ve2_r),
    .in_num   (num_e_r),
    .in_den   (den_e_r),
    .in_side  (ctxe2_r),
    .out_vld  (vy),
    .out_quo  (y),
    .out_side (sy)
  );

  // ---------------- exp(-y)
  logic             vx;
  logic [30:0]      e;
  logic [CTX_W-1:0] sx;

  sac_exp #(
    .SIDE_W (CTX_W)
  ) u_exp (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vy),
    .in_y     (y),
    .in_side  (sy),
    .out_vld  (vx),
    .out_e    (e),
    .out_side (sx)
  );

  // ---------------- P1..P3: pressure_q4 = round(base * 16 * e / (10 * 2^30))
  sac_pkg::ctx_t ctx_x;
  assign ctx_x = sac_pkg::ctx_t'(sx);

  logic          vp1_r;
  logic [54:0]   xp1_r;
  sac_pkg::ctx_t ctxp1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp1_r <= 1'b0;
    end else if (en) begin
      vp1_r <= vx;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xp1_r   <= (55'(sac_pkg::layer_base(ctx_x.lyr)) << 4) * 55'(e);
      ctxp1_r <= ctx_x;
    end
  end

  // floor(X / (10 * 2^30)) == floor(floor(X / 2^31) / 5)
  logic [55:0]   xr;
  logic          vp2_r;
  logic [24:0]   mq2_r;
  logic [36:0]   dd2_r;
  sac_pkg::ctx_t ctxp2_r;

  assign xr = 56'(xp1_r) + (56'd5 << sac_pkg::QBITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp2_r <= 1'b0;
    end else if (en) begin
      vp2_r <= vp1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mq2_r   <= xr[55:31];
      dd2_r   <= 37'(ctxp1_r.t) * 37'd28705;  // R * T
      ctxp2_r <= ctxp1_r;
    end
  end

  logic          vp3_r;
  logic [20:0]   pq3_r;
  logic [36:0]   dd3_r;
  sac_pkg::ctx_t ctxp3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp3_r <= 1'b0;
    end else if (en) begin
      vp3_r <= vp2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pq3_r   <= 21'(sac_pkg::recip_div(32'(mq2_r), RCP_5, 10'd5));
      dd3_r   <= dd2_r;
      ctxp3_r <= ctxp2_r;
    end
  end

  // ---------------- D1/D2: density numerator pq4 * 4096e6 + R*T/2
  logic          vd1_r;
  logic [52:0]   pd1_r;
  logic [20:0]   pq4d1_r;
  logic [36:0]   dd4_r;
  sac_pkg::ctx_t ctxd1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd1_r <= 1'b0;
    end else if (en) begin
      vd1_r <= vp3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pd1_r   <= 53'(pq3_r) * 53'(32'd4096000000);
      pq4d1_r <= pq3_r;
      dd4_r   <= dd3_r;
      ctxd1_r <= ctxp3_r;
    end
  end

  logic             vd2_r;
  logic [53:0]      nd2_r;
  logic [36:0]      dd5_r;
  logic [SD3_W-1:0] sd2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd2_r <= 1'b0;
    end else if (en) begin
      vd2_r <= vd1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nd2_r <= 54'(pd1_r) + 54'(dd4_r >> 1);
      dd5_r <= dd4_r;
      sd2_r <= {pq4d1_r, ctxd1_r};
    end
  end

  // ---------------- density divide
  logic             vq;
  logic [17:0]      dq;
  logic [SD3_W-1:0] sq;

  sac_div_pipe #(
    .NUM_W  (54),
    .DEN_W  (37),
    .QUO_W  (18),
    .SIDE_W (SD3_W)
  ) u_div_d (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vd2_r),
    .in_num   (nd2_r),
    .in_den   (dd5_r),
    .in_side  (sd2_r),
    .out_vld  (vq),
    .out_quo  (dq),
    .out_side (sq)
  );

  // ---------------- output register: saturate, zero the fields above range
  sac_pkg::ctx_t ctx_q;
  logic [20:0]   pq4_q;
  logic [16:0]   dens_q;

  assign ctx_q  = sac_pkg::ctx_t'(sq[CTX_W-1:0]);
  assign pq4_q  = sq[SD3_W-1:CTX_W];
  assign dens_q = (dq > 18'(sac_pkg::D_SAT)) ? sac_pkg::D_SAT : dq[16:0];

  logic [55:0] data_r;
  logic        oor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oor_r <= ctx_q.oor;
      if (ctx_q.oor) begin
        data_r <= 56'd0;
      end else begin
        data_r <= {1'b0, dens_q, pq4_q, ctx_q.tq8};
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = data_r;
  assign out_tuser  = oor_r;

`ifndef ASSERT_OFF
  // Above range every field is zero.
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 56'd0)
    else $error("out_of_range word carries nonzero data");

  // In-range results always have a positive temperature.
  a_temp_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[16:0] != 17'd0)
    else $error("in-range word with zero temperature");

  // A waiting result freezes the whole pipeline, input included.
  a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while the output stalls");

  // An accepted word enters the first stage.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v0_r)
    else $error("accepted word lost at the first stage");
`endif

endmodule

// ----- hw/rtl/sac_div_pipe.sv -----
// ----------------------------------------------------------------------------
// sac_div_pipe: pipelined restoring divider
// One quotient bit per stage, most significant first; a side word rides along.
// ----------------------------------------------------------------------------
module sac_div_pipe #(
  parameter int NUM_W  = 32,
  parameter int DEN_W  = 16,
  parameter int QUO_W  = 16,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [QUO_W-1:0]  out_quo,
  output logic [SIDE_W-1:0] out_side
);

  localparam int CW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic              vld_r  [QUO_W];
  logic [NUM_W-1:0]  rem_r  [QUO_W];
  logic [DEN_W-1:0]  den_r  [QUO_W];
  logic [QUO_W-1:0]  quo_r  [QUO_W];
  logic [SIDE_W-1:0] side_r [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    localparam int B = QUO_W - 1 - i;
    logic              vld_in;
    logic [NUM_W-1:0]  rem_in;
    logic [DEN_W-1:0]  den_in;
    logic [QUO_W-1:0]  quo_in;
    logic [SIDE_W-1:0] side_in;
    logic [CW-1:0]     trial;
    logic [CW-1:0]     diff;
    logic              fits;

    if (i == 0) begin : g_head
      assign vld_in  = in_vld;
      assign rem_in  = in_num;
      assign den_in  = in_den;
      assign quo_in  = '0;
      assign side_in = in_side;
    end else begin : g_body
      assign vld_in  = vld_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign den_in  = den_r[i-1];
      assign quo_in  = quo_r[i-1];
      assign side_in = side_r[i-1];
    end

    // Subtract the shifted divisor when it fits.
    assign trial = CW'(den_in) << B;
    assign fits  = CW'(rem_in) >= trial;
    assign diff  = CW'(rem_in) - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= fits ? diff[NUM_W-1:0] : rem_in;
        quo_r[i]  <= quo_in | (fits ? (QUO_W'(1) << B) : QUO_W'(0));
        den_r[i]  <= den_in;
        side_r[i] <= side_in;
      end
    end
  end

  assign out_vld  = vld_r[QUO_W-1];
  assign out_quo  = quo_r[QUO_W-1];
  assign out_side = side_r[QUO_W-1];

endmodule

// ----- hw/rtl/sac_series.sv -----
// ----------------------------------------------------------------------------
// sac_series: log-ratio series pipeline
// ln magnitude = 2 * atanh(u), odd series to u^11/11, one product per stage.
// ----------------------------------------------------------------------------
module sac_series #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [27:0]       in_u,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [28:0]       out_ln,
  output logic [SIDE_W-1:0] out_side
);

  localparam int NSTEP = 5;
  localparam logic [30:0] C11 = 31'((64'd1 << 30) / 11);

  logic              vld_r  [NSTEP+1];
  logic [27:0]       u_r    [NSTEP+1];
  logic [25:0]       u2_r   [NSTEP+1];
  logic [30:0]       acc_r  [NSTEP+1];
  logic [SIDE_W-1:0] side_r [NSTEP+1];

  logic [55:0] sq;
  assign sq = 56'(in_u) * 56'(in_u);

  // Square u.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r[0]    <= in_u;
      u2_r[0]   <= sq[55:30];
      acc_r[0]  <= C11;
      side_r[0] <= in_side;
    end
  end

  // Horner over u^2 with coefficients 1/9, 1/7, 1/5, 1/3, 1.
  for (genvar j = 1; j <= NSTEP; j++) begin : g_step
    localparam int DIVN = 11 - 2 * j;
    localparam logic [30:0] CN = 31'((64'd1 << 30) / DIVN);
    logic [56:0] prod;
    assign prod = 57'(u2_r[j-1]) * 57'(acc_r[j-1]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        u_r[j]    <= u_r[j-1];
        u2_r[j]   <= u2_r[j-1];
        acc_r[j]  <= CN + 31'(prod[56:30]);
        side_r[j] <= side_r[j-1];
      end
    end
  end

  logic [58:0] fin;
  logic        vld_out_r;
  logic [28:0] ln_r;
  logic [SIDE_W-1:0] side_out_r;

  assign fin = 59'(u_r[NSTEP]) * 59'(acc_r[NSTEP]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out_r <= 1'b0;
    end else if (en) begin
      vld_out_r <= vld_r[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ln_r       <= {fin[57:30], 1'b0};
      side_out_r <= side_r[NSTEP];
    end
  end

  assign out_vld  = vld_out_r;
  assign out_ln   = ln_r;
  assign out_side = side_out_r;

endmodule

// ----- hw/rtl/sac_exp.sv -----
// ----------------------------------------------------------------------------
// sac_exp: exp(-y) pipeline
// Range reduction by ln2, twelve Horner steps of two stages each, final shift.
// ----------------------------------------------------------------------------
module sac_exp #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [31:0]       in_y,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [30:0]       out_e,
  output logic [SIDE_W-1:0] out_side
);

  localparam int NTERM = 12;

  // Range reduction: k = floor(y / ln2) capped at 5, f = y - k * ln2.
  logic [2:0]  k_nxt;
  logic [34:0] kl;
  logic [29:0] f_nxt;

  always_comb begin
    k_nxt = 3'd0;
    for (int m = 1; m <= 5; m++) begin
      if (33'(in_y) >= 33'(m) * 33'(sac_pkg::LN2_Q)) begin
        k_nxt = 3'(m);
      end
    end
    kl    = 35'(k_nxt) * 35'(sac_pkg::LN2_Q);
    f_nxt = 30'(35'(in_y) - kl);
  end

  logic              v0_r;
  logic [2:0]        k0_r;
  logic [29:0]       f0_r;
  logic [SIDE_W-1:0] s0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k0_r <= k_nxt;
      f0_r <= f_nxt;
      s0_r <= in_side;
    end
  end

  logic              va_r [NTERM];
  logic [29:0]       ma_r [NTERM];
  logic [29:0]       fa_r [NTERM];
  logic [2:0]        ka_r [NTERM];
  logic [SIDE_W-1:0] sa_r [NTERM];
  logic              vb_r [NTERM];
  logic [30:0]       pb_r [NTERM];
  logic [29:0]       fb_r [NTERM];
  logic [2:0]        kb_r [NTERM];
  logic [SIDE_W-1:0] sb_r [NTERM];

  for (genvar j = 0; j < NTERM; j++) begin : g_term
    localparam int N = NTERM - j;
    logic              v_in;
    logic [30:0]       p_in;
    logic [29:0]       f_in;
    logic [2:0]        k_in;
    logic [SIDE_W-1:0] s_in;
    logic [60:0]       prod;
    logic [29:0]       q;

    if (j == 0) begin : g_head
      assign v_in = v0_r;
      assign p_in = sac_pkg::QONE;
      assign f_in = f0_r;
      assign k_in = k0_r;
      assign s_in = s0_r;
    end else begin : g_body
      assign v_in = vb_r[j-1];
      assign p_in = pb_r[j-1];
      assign f_in = fb_r[j-1];
      assign k_in = kb_r[j-1];
      assign s_in = sb_r[j-1];
    end

    assign prod = 61'(f_in) * 61'(p_in);

    if (N == 1) begin : g_unit
      assign q = ma_r[j];
    end else begin : g_div
      localparam logic [31:0] RCP = 32'((64'd1 << 32) / N);
      assign q = 30'(sac_pkg::recip_div(32'(ma_r[j]), RCP, 10'(N)));
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        va_r[j] <= 1'b0;
        vb_r[j] <= 1'b0;
      end else if (en) begin
        va_r[j] <= v_in;
        vb_r[j] <= va_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ma_r[j] <= prod[59:30];
        fa_r[j] <= f_in;
        ka_r[j] <= k_in;
        sa_r[j] <= s_in;
        pb_r[j] <= sac_pkg::QONE - 31'(q);
        fb_r[j] <= fa_r[j];
        kb_r[j] <= ka_r[j];
        sb_r[j] <= sa_r[j];
      end
    end
  end

  logic              ve_r;
  logic [30:0]       e_r;
  logic [SIDE_W-1:0] se_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (en) begin
      ve_r <= vb_r[NTERM-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_r  <= pb_r[NTERM-1] >> kb_r[NTERM-1];
      se_r <= sb_r[NTERM-1];
    end
  end

  assign out_vld  = ve_r;
  assign out_e    = e_r;
  assign out_side = se_r;

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for standard_atmosphere_calc
// Streams altitudes through the block, predicts temperature, pressure and
// density with an integer fixed-point model, and compares every result word.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 300;

  typedef struct packed {
    logic [16:0] tq8;
    logic [20:0] pq4;
    logic [16:0] dens;
    logic        oor;
  } atmo_t;

  // Natural log of a/b as magnitude, Q30, through the atanh series.
  function automatic logic [63:0] ln_mag(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] d, s, u, u2, acc;
    d = (a > b) ? a - b : b - a;
    s = a + b;
    if (s == 0) return 0;
    u   = ((d << 30) + s / 2) / s;
    u2  = (u * u) >> 30;
    acc = (64'd1 << 30) / 11;
    acc = (64'd1 << 30) / 9 + ((u2 * acc) >> 30);
    acc = (64'd1 << 30) / 7 + ((u2 * acc) >> 30);
    acc = (64'd1 << 30) / 5 + ((u2 * acc) >> 30);
    acc = (64'd1 << 30) / 3 + ((u2 * acc) >> 30);
    acc = (64'd1 << 30) + ((u2 * acc) >> 30);
    return 2 * ((u * acc) >> 30);
  endfunction

  function automatic logic [63:0] grad_y(input logic [63:0] t, input logic [63:0] tb,
                                         input logic [63:0] lapse);
    logic [63:0] den;
    den = lapse * 28705;
    return (ln_mag(t, tb) * 980665 * 10 + den / 2) / den;
  endfunction

  function automatic logic [63:0] iso_y(input logic [63:0] dh, input logic [63:0] t_e2);
    logic [63:0] num, den, q, r;
    num = 980665 * dh;
    den = 10 * 28705 * t_e2;
    q = num / den;
    r = num % den;
    return (q << 30) + ((r << 30) + den / 2) / den;
  endfunction

  function automatic logic [63:0] exp_neg_q30(input logic [63:0] y);
    logic [63:0] k, f, p;
    k = y / 744261118;
    f = y - k * 744261118;
    p = 64'd1 << 30;
    for (int n = 12; n >= 1; n--) p = (64'd1 << 30) - ((f * p) >> 30) / n;
    if (k >= 31) return 0;
    return p >> k;
  endfunction

  function automatic atmo_t atmo_predict(input logic [15:0] alt);
    logic [63:0] h, t, y, base, pq4, den, dens;
    atmo_t r;
    h = alt;
    r = '0;
    if (h > 51000) begin
      r.oor = 1'b1;
      return r;
    end
    if (h < 11000)       t = 2881600 - 65 * h;
    else if (h <= 20000) t = 2161600;
    else if (h <= 32000) t = 2161600 + 10 * (h - 20000);
    else if (h <= 47000) t = 2281600 + 28 * (h - 32000);
    else                 t = 2701600;
    r.tq8 = 17'((t * 256 + 5000) / 10000);
    // the seam at 11000 m still takes the first-layer power law
    if (h <= 11000)      begin y = grad_y(t, 2881600, 65); base = 1013250; end
    else if (h <= 20000) begin y = iso_y(h - 11000, 21616); base = 226321; end
    else if (h <= 32000) begin y = grad_y(t, 2161600, 10); base = 54555; end
    else if (h <= 47000) begin y = grad_y(t, 2281600, 28); base = 8585; end
    else                 begin y = iso_y(h - 47000, 27016); base = 1089; end
    pq4 = (base * 16 * exp_neg_q30(y) + 5 * (64'd1 << 30)) / (10 * (64'd1 << 30));
    den = 28705 * t;
    dens = (pq4 * 64'd4096000000 + den / 2) / den;
    if (dens > 131071) dens = 131071;
    r.pq4  = 21'(pq4);
    r.dens = 17'(dens);
    return r;
  endfunction

  class atmo_scoreboard;
    atmo_t pending[$];
    int    errors;

    function void note_altitude(logic [15:0] alt);
      pending.push_back(atmo_predict(alt));
    endfunction

    function void check_word(logic [55:0] data, logic flag);
      atmo_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word data=%h flag=%b", $time, data, flag);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (data[16:0] !== e.tq8) begin
        $display("%0t: temperature exp %0d got %0d", $time, e.tq8, data[16:0]);
        errors++;
      end
      if (data[37:17] !== e.pq4) begin
        $display("%0t: pressure exp %0d got %0d", $time, e.pq4, data[37:17]);
        errors++;
      end
      if (data[54:38] !== e.dens) begin
        $display("%0t: density exp %0d got %0d", $time, e.dens, data[54:38]);
        errors++;
      end
      if (data[55] !== 1'b0) begin
        $display("%0t: pad bit exp 0 got %b", $time, data[55]);
        errors++;
      end
      if (flag !== e.oor) begin
        $display("%0t: out_of_range exp %b got %b", $time, e.oor, flag);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        out_tuser;

  atmo_scoreboard sb = new();
  int  send_idle_pct = 0;   // chance per cycle that the sender holds off
  int  recv_stall_pct = 0;  // chance per cycle that the receiver stalls
  bit  hold_off = 1'b0;     // long receiver stall, forces backpressure
  int  quiet_cycles = 0;

  always #1 clk = ~clk;

  standard_atmosphere_calc u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  // Receiver: randomly stall, or hold off entirely while hold_off is set.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check every accepted result word.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata, out_tuser);
  end

  // Watchdog: count cycles with no word moving on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offer one altitude; hold it until accepted, then maybe idle.
  task automatic send_altitude(input logic [15:0] alt);
    in_tvalid <= 1'b1;
    in_tdata  <= alt;
    do @(posedge clk); while (!in_tready);
    sb.note_altitude(alt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic logic [15:0] random_altitude();
    case ($urandom_range(9))
      0:       return 16'($urandom_range(65535));
      1:       return 16'($urandom_range(65535, 51001));
      2: begin
        // land near one of the layer seams or the 51000 m range limit
        case ($urandom_range(4))
          0: return 16'($urandom_range(11005, 10995));
          1: return 16'($urandom_range(20005, 19995));
          2: return 16'($urandom_range(32005, 31995));
          3: return 16'($urandom_range(47005, 46995));
          default: return 16'($urandom_range(51002, 50995));
        endcase
      end
      default: return 16'($urandom_range(51000));
    endcase
  endfunction

  task automatic run_phase(input int count, input int idle, input int stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    repeat (count) send_altitude(random_altitude());
  endtask

  // Long receiver stall while the sender keeps offering words.
  initial begin
    wait (rst_n);
    repeat (400) @(posedge clk);
    hold_off <= 1'b1;
    repeat (600) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    logic [15:0] directed[$];
    int          wait_cycles;
    directed = '{16'd0, 16'd1, 16'd10999, 16'd11000, 16'd11001, 16'd15000,
                 16'd20000, 16'd20001, 16'd26000, 16'd32000, 16'd32001,
                 16'd40000, 16'd47000, 16'd47001, 16'd49000, 16'd51000,
                 16'd51001, 16'd65535, 16'h5555, 16'hAAAA, 16'h8000, 16'h7FFF};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send_altitude(directed[i]);
    run_phase(180, 0, 0);
    run_phase(170, 77, 0);
    run_phase(170, 0, 77);
    run_phase(180, 9, 9);
    in_tvalid <= 1'b0;
    // drain: wait for the pipeline to empty, then a little more
    wait_cycles = 0;
    while (sb.pending.size() != 0 && wait_cycles < WATCHDOG_LIMIT * 4) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- standard_atmosphere_calc.f -----
hw/rtl/sac_pkg.sv
hw/rtl/sac_div_pipe.sv
hw/rtl/sac_series.sv
hw/rtl/sac_exp.sv
hw/rtl/standard_atmosphere_calc.sv
test/tb_top.sv
